// File: rtl/core/pws_pkg.sv
package pws_pkg;

  typedef struct packed {
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
  } point_t;

  typedef struct packed {
    logic               visible;
    logic signed [23:0] screen_x;
    logic signed [23:0] screen_y;
  } result_t;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned ViewW    = 14;
  localparam int unsigned ScaleW   = ViewW + 7;
  localparam int unsigned TermW    = 42;
  localparam int unsigned QuoW     = 41;

  localparam logic [CfgIdxW-1:0] REG_ROW0_A  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ROW0_B  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ROW1_A  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ROW1_B  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ROW3_A  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_ROW3_B  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_VIEW_W  = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_VIEW_H  = 3'd7;

  localparam logic [ViewW-1:0] VIEW_W_RESET = 14'd1920;
  localparam logic [ViewW-1:0] VIEW_H_RESET = 14'd1080;

  // Smallest w in Q.22 that still counts as visible: ceil(0.001 * 2^22).
  localparam logic signed [63:0] VIS_MIN = 64'sd4195;

  localparam logic [QuoW-1:0] TERM_CAP = {1'b1, {(QuoW-1){1'b0}}};

  localparam logic signed [23:0] OUT_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] OUT_MIN = 24'sh800000;

endpackage

// File: rtl/core/perspective_world_to_screen.sv
// Projects one world point per clock to viewport pixels. A point is taken at
// every edge where start is high (busy stays low), and its result appears on
// result_o, marked by done_o for one cycle, in the order the points came in.
// The bulk of the pipeline is the divider of the viewport mapping, which
// resolves one quotient bit per pipeline stage (41 stages), behind two stages
// of matrix products and sums and four stages of scaling. Results cannot be
// held off. Configuration writes take effect at once and are meant to be made
// while no point is in flight.
module perspective_world_to_screen (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  pws_pkg::point_t                   point_i,
  output logic                              done_o,
  output pws_pkg::result_t                  result_o,
  input  logic                              cfg_we_i,
  input  logic [pws_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [pws_pkg::CfgDataW-1:0]      cfg_data_i
);

  localparam int unsigned Latency = 49;

  logic [63:0] row0_a_q, row0_b_q, row1_a_q, row1_b_q, row3_a_q, row3_b_q;
  logic [pws_pkg::ViewW-1:0] view_w_q, view_h_q;

  logic               in_valid;
  logic               dx_valid, dy_valid, dw_valid;
  logic signed [63:0] dx_sum, dy_sum, dw_sum;
  logic               w_vis;
  logic               vx_valid, vy_valid, vx_vis, vy_vis;
  logic signed [pws_pkg::TermW-1:0] term_x, term_y;

  logic               done_q;
  pws_pkg::result_t   result_q, result_d;
  logic signed [43:0] sx, sy, cx, cy;

  assign busy     = 1'b0;
  assign in_valid = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row0_a_q <= '0;
      row0_b_q <= '0;
      row1_a_q <= '0;
      row1_b_q <= '0;
      row3_a_q <= '0;
      row3_b_q <= '0;
      view_w_q <= pws_pkg::VIEW_W_RESET;
      view_h_q <= pws_pkg::VIEW_H_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pws_pkg::REG_ROW0_A: row0_a_q <= cfg_data_i;
        pws_pkg::REG_ROW0_B: row0_b_q <= cfg_data_i;
        pws_pkg::REG_ROW1_A: row1_a_q <= cfg_data_i;
        pws_pkg::REG_ROW1_B: row1_b_q <= cfg_data_i;
        pws_pkg::REG_ROW3_A: row3_a_q <= cfg_data_i;
        pws_pkg::REG_ROW3_B: row3_b_q <= cfg_data_i;
        pws_pkg::REG_VIEW_W: view_w_q <= cfg_data_i[pws_pkg::ViewW-1:0];
        pws_pkg::REG_VIEW_H: view_h_q <= cfg_data_i[pws_pkg::ViewW-1:0];
        default: ;
      endcase
    end
  end

  pws_dot u_dot_x (
    .clk_i, .rst_ni, .valid_i(in_valid), .point_i,
    .row_a_i(row0_a_q), .row_b_i(row0_b_q), .valid_o(dx_valid), .sum_o(dx_sum)
  );

  pws_dot u_dot_y (
    .clk_i, .rst_ni, .valid_i(in_valid), .point_i,
    .row_a_i(row1_a_q), .row_b_i(row1_b_q), .valid_o(dy_valid), .sum_o(dy_sum)
  );

  pws_dot u_dot_w (
    .clk_i, .rst_ni, .valid_i(in_valid), .point_i,
    .row_a_i(row3_a_q), .row_b_i(row3_b_q), .valid_o(dw_valid), .sum_o(dw_sum)
  );

  assign w_vis = dw_sum >= pws_pkg::VIS_MIN;

  pws_div u_div_x (
    .clk_i, .rst_ni, .valid_i(dx_valid), .vis_i(w_vis), .num_i(dx_sum),
    .den_i(dw_sum), .scale_i({view_w_q, 7'd0}),
    .valid_o(vx_valid), .vis_o(vx_vis), .term_o(term_x)
  );

  pws_div u_div_y (
    .clk_i, .rst_ni, .valid_i(dy_valid && dw_valid), .vis_i(w_vis), .num_i(dy_sum),
    .den_i(dw_sum), .scale_i({view_h_q, 7'd0}),
    .valid_o(vy_valid), .vis_o(vy_vis), .term_o(term_y)
  );

  function automatic logic signed [23:0] sat24(input logic signed [43:0] v);
    logic signed [23:0] r;
    if (v > 44'(pws_pkg::OUT_MAX)) begin
      r = pws_pkg::OUT_MAX;
    end else if (v < 44'(pws_pkg::OUT_MIN)) begin
      r = pws_pkg::OUT_MIN;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  always_comb begin
    cx = $signed({23'd0, view_w_q[pws_pkg::ViewW-1:1], 8'd0});
    cy = $signed({23'd0, view_h_q[pws_pkg::ViewW-1:1], 8'd0});
    sx = cx + 44'(term_x);
    sy = cy - 44'(term_y);
    result_d = '0;
    if (vx_vis) begin
      result_d.visible  = 1'b1;
      result_d.screen_x = sat24(sx);
      result_d.screen_y = sat24(sy);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vx_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid |-> ##Latency done_o)
    else $error("transaction did not complete after the pipeline latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(in_valid, Latency))
    else $error("result without a matching input transaction");

  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vx_valid == vy_valid && (!vx_valid || vx_vis == vy_vis))
    else $error("x and y divider lanes out of step");

  a_hidden_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.visible) |-> (result_o.screen_x == 24'sd0 &&
                                       result_o.screen_y == 24'sd0))
    else $error("hidden point with nonzero coordinates");

endmodule

// File: rtl/core/pws_dot.sv
module pws_dot (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  pws_pkg::point_t     point_i,
  input  logic [63:0]         row_a_i,
  input  logic [63:0]         row_b_i,
  output logic                valid_o,
  output logic signed [63:0]  sum_o
);

  logic               a_valid_q;
  logic signed [63:0] p0_q, p1_q, p2_q;
  logic signed [31:0] c3_q;
  logic               b_valid_q;
  logic signed [63:0] sum_q;
  logic signed [63:0] sum_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p0_q  <= $signed(row_a_i[31:0])  * point_i.world_x;
    p1_q  <= $signed(row_a_i[63:32]) * point_i.world_y;
    p2_q  <= $signed(row_b_i[31:0])  * point_i.world_z;
    c3_q  <= $signed(row_b_i[63:32]);
    sum_q <= sum_d;
  end

  // Each product is floored from Q.24 to Q.22; the constant column is Q.16.
  always_comb begin
    sum_d = (p0_q >>> 2) + (p1_q >>> 2) + (p2_q >>> 2) +
            ($signed({{32{c3_q[31]}}, c3_q}) <<< 6);
  end

  assign valid_o = b_valid_q;
  assign sum_o   = sum_q;

endmodule

// File: rtl/core/pws_div.sv
module pws_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic                              vis_i,
  input  logic signed [63:0]                num_i,
  input  logic signed [63:0]                den_i,
  input  logic [pws_pkg::ScaleW-1:0]        scale_i,
  output logic                              valid_o,
  output logic                              vis_o,
  output logic signed [pws_pkg::TermW-1:0]  term_o
);

  localparam int unsigned Q = pws_pkg::QuoW;

  // Front stages: magnitude, partial products, rounded numerator.
  logic        s0_val_q, s1_val_q, s2_val_q;
  logic        s0_vis_q, s1_vis_q, s2_vis_q;
  logic        s0_sgn_q, s1_sgn_q, s2_sgn_q;
  logic [62:0] s0_den_q, s1_den_q, s2_den_q;
  logic [62:0] s0_mag_q;
  logic [pws_pkg::ScaleW-1:0] s0_scale_q;
  logic [31+pws_pkg::ScaleW:0] s1_plo_q;
  logic [30+pws_pkg::ScaleW:0] s1_phi_q;
  logic [84:0] s2_num_q;
  logic [63:0] mag_d;

  // One quotient bit per stage; entry 0 is loaded from the numerator stage.
  logic          st_val_q  [0:Q];
  logic          st_vis_q  [0:Q];
  logic          st_sgn_q  [0:Q];
  logic          st_over_q [0:Q];
  logic [62:0]   st_den_q  [0:Q];
  logic [62:0]   st_rem_q  [0:Q];
  logic [Q-1:0]  st_low_q  [0:Q];
  logic [Q-1:0]  st_quo_q  [0:Q];

  logic                           f_val_q, f_vis_q;
  logic signed [pws_pkg::TermW-1:0] f_term_q;
  logic [Q-1:0]                   q_cap;

  assign mag_d = num_i[63] ? (64'd0 - num_i) : num_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_val_q <= 1'b0;
      s1_val_q <= 1'b0;
      s2_val_q <= 1'b0;
      st_val_q[0] <= 1'b0;
      f_val_q <= 1'b0;
    end else begin
      s0_val_q <= valid_i;
      s1_val_q <= s0_val_q;
      s2_val_q <= s1_val_q;
      st_val_q[0] <= s2_val_q;
      f_val_q <= st_val_q[Q];
    end
  end

  always_ff @(posedge clk_i) begin
    s0_vis_q   <= vis_i;
    s0_sgn_q   <= num_i[63];
    s0_den_q   <= den_i[62:0];
    s0_mag_q   <= mag_d[62:0];
    s0_scale_q <= scale_i;

    s1_vis_q <= s0_vis_q;
    s1_sgn_q <= s0_sgn_q;
    s1_den_q <= s0_den_q;
    s1_plo_q <= s0_mag_q[31:0] * s0_scale_q;
    s1_phi_q <= s0_mag_q[62:32] * s0_scale_q;

    s2_vis_q <= s1_vis_q;
    s2_sgn_q <= s1_sgn_q;
    s2_den_q <= s1_den_q;
    s2_num_q <= 85'(s1_plo_q) + {1'b0, s1_phi_q, 32'd0} + 85'(s1_den_q[62:1]);

    // A quotient of 2^41 or more is capped anyway.
    st_vis_q[0]  <= s2_vis_q;
    st_sgn_q[0]  <= s2_sgn_q;
    st_den_q[0]  <= s2_den_q;
    st_over_q[0] <= {19'd0, s2_num_q} >= {s2_den_q, 41'd0};
    st_rem_q[0]  <= 63'(s2_num_q[84:41]);
    st_low_q[0]  <= s2_num_q[40:0];
    st_quo_q[0]  <= '0;
  end

  for (genvar k = 0; k < Q; k++) begin : g_stage
    logic [63:0] trial;
    logic        take;

    assign trial = {st_rem_q[k], st_low_q[k][Q-1-k]};
    assign take  = trial >= {1'b0, st_den_q[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_val_q[k+1] <= 1'b0;
      end else begin
        st_val_q[k+1] <= st_val_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      st_vis_q[k+1]  <= st_vis_q[k];
      st_sgn_q[k+1]  <= st_sgn_q[k];
      st_over_q[k+1] <= st_over_q[k];
      st_den_q[k+1]  <= st_den_q[k];
      st_low_q[k+1]  <= st_low_q[k];
      st_rem_q[k+1]  <= take ? 63'(trial - {1'b0, st_den_q[k]}) : trial[62:0];
      st_quo_q[k+1]  <= {st_quo_q[k][Q-2:0], take};
    end
  end

  always_comb begin
    q_cap = st_quo_q[Q];
    if (st_over_q[Q] || (st_quo_q[Q] > pws_pkg::TERM_CAP)) begin
      q_cap = pws_pkg::TERM_CAP;
    end
  end

  always_ff @(posedge clk_i) begin
    f_vis_q  <= st_vis_q[Q];
    f_term_q <= st_sgn_q[Q] ? -$signed({1'b0, q_cap}) : $signed({1'b0, q_cap});
  end

  assign valid_o = f_val_q;
  assign vis_o   = f_vis_q;
  assign term_o  = f_term_q;

endmodule

// File: sim/tb_perspective_world_to_screen.sv
`timescale 1ns / 100ps

module tb_perspective_world_to_screen;

  localparam int unsigned DrainCycles = 64;
  localparam int unsigned CycleLimit  = 1000000;

  class projection_scoreboard;
    logic [63:0]          regs[8];
    pws_pkg::result_t     pending[$];
    int unsigned          errors;

    function new();
      for (int i = 0; i < 6; i++) regs[i] = '0;
      regs[pws_pkg::REG_VIEW_W] = 64'(pws_pkg::VIEW_W_RESET);
      regs[pws_pkg::REG_VIEW_H] = 64'(pws_pkg::VIEW_H_RESET);
      errors = 0;
    endfunction

    function void write_reg(logic [pws_pkg::CfgIdxW-1:0] idx, logic [63:0] value);
      if (idx == pws_pkg::REG_VIEW_W || idx == pws_pkg::REG_VIEW_H)
        regs[idx] = value & 64'h3FFF;
      else regs[idx] = value;
    endfunction

    // Dot product of one matrix row with the point, each product floored to Q.22.
    function logic signed [63:0] row_dot(logic [63:0] ra, logic [63:0] rb,
                                         pws_pkg::point_t p);
      logic signed [63:0] c0, c1, c2, c3, px, py, pz, s;
      c0 = $signed(ra[31:0]);
      c1 = $signed(ra[63:32]);
      c2 = $signed(rb[31:0]);
      c3 = $signed(rb[63:32]);
      px = p.world_x;
      py = p.world_y;
      pz = p.world_z;
      s = ((c0 * px) >>> 2) + ((c1 * py) >>> 2) + ((c2 * pz) >>> 2) + (c3 <<< 6);
      return s;
    endfunction

    // Rounded |num| * scale / den with the sign of num, magnitude capped at 2^40.
    function logic signed [63:0] offset_term(logic signed [63:0] num, logic [63:0] scale,
                                             logic signed [63:0] den);
      logic [63:0]  mag;
      logic [127:0] n, q;
      logic signed [63:0] t;
      mag = (num < 0) ? 64'(-num) : 64'(num);
      n = 128'(mag) * 128'(scale) + 128'(den / 2);
      q = n / 128'(den);
      if (q > 128'(pws_pkg::TERM_CAP)) q = 128'(pws_pkg::TERM_CAP);
      t = $signed(q[63:0]);
      return (num < 0) ? -t : t;
    endfunction

    function logic signed [23:0] sat24(logic signed [63:0] v);
      if (v > 64'sd8388607) return pws_pkg::OUT_MAX;
      if (v < -64'sd8388608) return pws_pkg::OUT_MIN;
      return v[23:0];
    endfunction

    function void note_point(pws_pkg::point_t p);
      logic signed [63:0] x, y, w, sx, sy;
      logic [63:0] wd, ht;
      pws_pkg::result_t r;
      r = '0;
      w = row_dot(regs[pws_pkg::REG_ROW3_A], regs[pws_pkg::REG_ROW3_B], p);
      if (w >= pws_pkg::VIS_MIN) begin
        wd = regs[pws_pkg::REG_VIEW_W] & 64'h3FFF;
        ht = regs[pws_pkg::REG_VIEW_H] & 64'h3FFF;
        x = row_dot(regs[pws_pkg::REG_ROW0_A], regs[pws_pkg::REG_ROW0_B], p);
        y = row_dot(regs[pws_pkg::REG_ROW1_A], regs[pws_pkg::REG_ROW1_B], p);
        sx = $signed(64'((wd >> 1) * 256)) + offset_term(x, wd * 128, w);
        sy = $signed(64'((ht >> 1) * 256)) - offset_term(y, ht * 128, w);
        r.visible  = 1'b1;
        r.screen_x = sat24(sx);
        r.screen_y = sat24(sy);
      end
      pending.insert(pending.size(), r);
    endfunction

    function void check_result(pws_pkg::result_t got);
      pws_pkg::result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.visible !== exp_r.visible) begin
        $display("%0t: visible expected %b actual %b", $time, exp_r.visible, got.visible);
        errors++;
      end
      if (got.screen_x !== exp_r.screen_x) begin
        $display("%0t: screen_x expected %h actual %h", $time, exp_r.screen_x, got.screen_x);
        errors++;
      end
      if (got.screen_y !== exp_r.screen_y) begin
        $display("%0t: screen_y expected %h actual %h", $time, exp_r.screen_y, got.screen_y);
        errors++;
      end
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         start;
  logic                         busy;
  pws_pkg::point_t              point_i;
  logic                         done_o;
  pws_pkg::result_t             result_o;
  logic                         cfg_we_i;
  logic [pws_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [pws_pkg::CfgDataW-1:0] cfg_data_i;

  projection_scoreboard sb = new();
  int unsigned cycles;

  perspective_world_to_screen u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .point_i    (point_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) sb.note_point(point_i);
      if (done_o) sb.check_result(result_o);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Entered and left at a falling edge.
  task automatic write_reg(logic [pws_pkg::CfgIdxW-1:0] idx, logic [63:0] value);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    @(posedge clk_i);
    sb.write_reg(idx, value);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic drain();
    start = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic send_point(pws_pkg::point_t p);
    start   = 1'b1;
    point_i = p;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic idle_gap();
    int unsigned r, n;
    r = $urandom_range(99);
    if (r < 60) n = 0;
    else if (r < 92) n = $urandom_range(3, 1);
    else n = $urandom_range(40, 8);
    if (n != 0) begin
      start = 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  function automatic logic [31:0] q16(int signed v);
    return 32'(v);
  endfunction

  function automatic pws_pkg::point_t mk_point(int signed x, int signed y, int signed z);
    pws_pkg::point_t p;
    p.world_x = x;
    p.world_y = y;
    p.world_z = z;
    return p;
  endfunction

  // A camera-like matrix: w grows with z, x and y use moderate coefficients.
  task automatic load_camera(logic [13:0] wd, logic [13:0] ht);
    logic [31:0] c[12];
    for (int i = 0; i < 12; i++) c[i] = q16($signed($urandom_range(262144)) - 131072);
    c[10] = q16($urandom_range(131072, 1));
    c[11] = q16($signed($urandom_range(65536)) - 16384);
    c[8]  = q16($signed($urandom_range(4096)) - 2048);
    c[9]  = q16($signed($urandom_range(4096)) - 2048);
    write_reg(pws_pkg::REG_ROW0_A, {c[1], c[0]});
    write_reg(pws_pkg::REG_ROW0_B, {c[3], c[2]});
    write_reg(pws_pkg::REG_ROW1_A, {c[5], c[4]});
    write_reg(pws_pkg::REG_ROW1_B, {c[7], c[6]});
    write_reg(pws_pkg::REG_ROW3_A, {c[9], c[8]});
    write_reg(pws_pkg::REG_ROW3_B, {c[11], c[10]});
    write_reg(pws_pkg::REG_VIEW_W, {$urandom, 18'($urandom), wd});
    write_reg(pws_pkg::REG_VIEW_H, {$urandom, 18'($urandom), ht});
  endtask

  task automatic load_random_matrix();
    for (int i = 0; i < 6; i++) write_reg((pws_pkg::CfgIdxW)'(i), {$urandom, $urandom});
  endtask

  function automatic logic [13:0] pick_view();
    case ($urandom_range(5))
      0: return 14'd1;
      1: return 14'd8192;
      2: return 14'($urandom_range(64, 1));
      default: return 14'($urandom_range(8192, 1));
    endcase
  endfunction

  function automatic pws_pkg::point_t rand_point(bit wild);
    if (wild || $urandom_range(9) == 0)
      return mk_point($urandom, $urandom, $urandom);
    return mk_point($signed($urandom_range(131072)) - 65536,
                    $signed($urandom_range(131072)) - 65536,
                    $signed($urandom_range(200000)) - 8000);
  endfunction

  initial begin
    bit wild;
    start      = 1'b0;
    point_i    = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    cycles     = 0;
    rst_ni     = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset configuration: all-zero matrix, so every point is invisible.
    send_point(mk_point(32'sh7FFFFFFF, 32'sh80000000, 256));
    drain();

    // Identity for x and y, w = floor(z / 4) puts the visibility edge at z = 16780.
    write_reg(pws_pkg::REG_ROW0_A, {q16(0), q16(65536)});
    write_reg(pws_pkg::REG_ROW0_B, '0);
    write_reg(pws_pkg::REG_ROW1_A, {q16(65536), q16(0)});
    write_reg(pws_pkg::REG_ROW1_B, '0);
    write_reg(pws_pkg::REG_ROW3_A, '0);
    write_reg(pws_pkg::REG_ROW3_B, {q16(0), q16(1)});
    send_point(mk_point(256, 256, 16780));
    send_point(mk_point(256, 256, 16779));
    send_point(mk_point(-256, -256, 16780));
    send_point(mk_point(0, 0, 0));
    send_point(mk_point(100, -100, -16780));
    send_point(mk_point(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF));
    send_point(mk_point(32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF));
    send_point(mk_point(32'sh7FFFFFFF, 32'sh80000000, 16780));
    send_point(mk_point(1, -1, 32'sh7FFFFFFF));
    send_point(mk_point(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000));
    drain();

    // Viewport extremes, including out-of-range sizes, with a large constant column.
    write_reg(pws_pkg::REG_ROW0_B, {q16(32'sh7FFFFFFF), q16(0)});
    write_reg(pws_pkg::REG_ROW1_B, {q16(32'sh80000000), q16(0)});
    write_reg(pws_pkg::REG_ROW3_B, {q16(4), q16(65536)});
    write_reg(pws_pkg::REG_VIEW_W, 64'd0);
    write_reg(pws_pkg::REG_VIEW_H, 64'd16383);
    send_point(mk_point(0, 0, 1));
    send_point(mk_point(512, -512, 256));
    send_point(mk_point(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF));
    drain();
    write_reg(pws_pkg::REG_VIEW_W, 64'd8192);
    write_reg(pws_pkg::REG_VIEW_H, 64'd1);
    send_point(mk_point(0, 0, 1));
    send_point(mk_point(-512, 512, 256));
    send_point(mk_point(32'sh80000000, 32'sh7FFFFFFF, 16));
    drain();

    for (int phase = 0; phase < 10; phase++) begin
      wild = (phase % 5 == 4);
      if (wild) begin
        load_random_matrix();
        write_reg(pws_pkg::REG_VIEW_W, 64'(pick_view()));
        write_reg(pws_pkg::REG_VIEW_H, 64'(pick_view()));
      end else begin
        load_camera(pick_view(), pick_view());
      end
      for (int n = 0; n < 200; n++) begin
        send_point(rand_point(wild));
        if (n == 100 && phase == 3) drain();
        else idle_gap();
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
